// File: hdl/lpfr_pkg.sv
// Package for the length-prefixed frame receiver.
// Holds framing byte codes, error codes, parser phases and the result struct.
// No dependencies.
package lpfr_pkg;

  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned LenWidth     = 16;

  localparam logic [7:0] ByteSoh = 8'h01;
  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEtx = 8'h03;

  localparam logic [LenWidth-1:0] FramingBytes  = 16'd5;
  localparam logic [LenWidth-1:0] MaxLenDefault = 16'd1024;

  // register index of max_total_length
  localparam logic RegMaxLen = 1'b0;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_SOH    = 3'd1,
    ERR_LENGTH = 3'd2,
    ERR_STX    = 3'd3,
    ERR_ETX    = 3'd4
  } err_e;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN_HI  = 6'b000010,
    PH_LEN_LO  = 6'b000100,
    PH_STX     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_ETX     = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    err_e       frame_error;
  } result_t;

endpackage

// File: hdl/lpfr_apb_regs.sv
// APB register file of the frame receiver: holds max_total_length.
// Depends on lpfr_pkg.
module lpfr_apb_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpfr_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [lpfr_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [lpfr_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                 pready,
  output logic [lpfr_pkg::LenWidth-1:0]        max_len_o
);
  import lpfr_pkg::*;

  logic [LenWidth-1:0] max_len_q, max_len_d;
  logic                wr_en;
  logic                sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[ApbAddrWidth-1] == RegMaxLen);
  assign wr_en   = psel & penable & pwrite & pready & sel_max;

  always_comb begin
    max_len_d = max_len_q;
    if (wr_en) begin
      max_len_d = pwdata[LenWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenDefault;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata    = sel_max ? {{(ApbDataWidth-LenWidth){1'b0}}, max_len_q} : '0;
  assign max_len_o = max_len_q;

endmodule

// File: hdl/lpfr_parser.sv
// Frame parser: phase, length high byte and remaining payload count.
// Computes one result per byte; state advances when the pipeline moves.
// Depends on lpfr_pkg.
module lpfr_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [lpfr_pkg::LenWidth-1:0] max_len_i,
  output lpfr_pkg::result_t             result_o
);
  import lpfr_pkg::*;

  phase_e              phase_q, phase_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [LenWidth-1:0] left_q, left_d;
  logic [LenWidth-1:0] total;
  logic [LenWidth-1:0] left_dec;
  result_t             res;

  assign total    = {len_hi_q, rx_byte_i};
  assign left_dec = (left_q != '0) ? left_q - 16'd1 : left_q;

  always_comb begin
    phase_d = phase_q;
    len_hi_d = len_hi_q;
    left_d = left_q;
    res = '{payload_byte: 8'h00, payload_valid: 1'b0, frame_end: 1'b0,
            frame_error: ERR_NONE};
    case (phase_q)
      PH_LEN_HI: begin
        len_hi_d = rx_byte_i;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if ((total < FramingBytes) || (total > max_len_i)) begin
          res.frame_error = ERR_LENGTH;
          phase_d = PH_HUNT;
        end else begin
          left_d  = total - FramingBytes;
          phase_d = PH_STX;
        end
      end
      PH_STX: begin
        if (rx_byte_i != ByteStx) begin
          res.frame_error = ERR_STX;
          phase_d = PH_HUNT;
        end else begin
          phase_d = (left_q == '0) ? PH_ETX : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.payload_byte  = rx_byte_i;
        res.payload_valid = 1'b1;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_ETX;
        end
      end
      PH_ETX: begin
        if (rx_byte_i == ByteEtx) begin
          res.frame_end = 1'b1;
        end else begin
          res.frame_error = ERR_ETX;
        end
        phase_d = PH_HUNT;
      end
      default: begin
        if (rx_byte_i == ByteSoh) begin
          phase_d = PH_LEN_HI;
        end else begin
          res.frame_error = ERR_SOH;
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_hi_q <= 8'h00;
      left_q   <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
    end
  end

  assign result_o = res;

  a_err_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (res.frame_error != ERR_NONE) |=> phase_q == PH_HUNT)
    else $error("parser did not return to hunting after an error");

  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res.frame_end |=> phase_q == PH_HUNT)
    else $error("parser did not return to hunting after end of frame");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.payload_valid |-> (res.frame_error == ERR_NONE) && !res.frame_end)
    else $error("payload byte flagged together with end or error");

  a_etx_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (phase_q == PH_PAYLOAD) && (left_q == 16'd1) |=> phase_q == PH_ETX)
    else $error("last payload byte did not lead to the ETX check");

endmodule

// File: hdl/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver.
// Instantiates lpfr_apb_regs and lpfr_parser; depends on lpfr_pkg.
//
// Usage:
//   Feed received link bytes on the s_axis channel (tdata = rx_byte), one
//   transaction per byte. Every input byte yields exactly one output
//   transaction on m_axis: tdata carries the payload byte (zero when none),
//   tuser[0] flags a payload byte, tuser[3:1] carries the error code
//   (0 none, 1 not SOH, 2 bad length, 3 not STX, 4 not ETX) and tlast marks
//   a correct ETX that closed the frame.
//   max_total_length sits at APB address 0 (reset value 1024); write it
//   only while no byte is in flight.
// Pipeline and throughput:
//   A byte is captured in the input register, parsed there by the phase logic
//   and lands in the output register once that register is free or draining.
//   One byte per cycle is sustained while m_axis_tready stays high; the
//   single-byte phase update is the only work per transaction.
// Reset: rst_ni clears both pipeline valids, the parser returns to hunting
//   for SOH and max_total_length returns to 1024.
// Stall: while m_axis_tready is low the result holds; one more byte is
//   taken into the input register, then s_axis_tready drops.
module length_prefixed_frame_receiver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] rx_byte
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [7:0] payload_byte
  output logic [3:0]                           m_axis_tuser,  // [0] payload_valid,
                                                              // [3:1] frame_error
  output logic                                 m_axis_tlast,  // frame_end
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpfr_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [lpfr_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [lpfr_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                 pready
);
  import lpfr_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [7:0]          in_byte_q;
  logic                out_valid_q, out_valid_d;
  result_t             out_res_q;
  result_t             parse_res;
  logic [LenWidth-1:0] max_len;
  logic                advance;
  logic                in_take;

  lpfr_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // Move the captured byte into the result register whenever the result
  // slot is empty or being drained this cycle.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  lpfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (in_byte_q),
    .max_len_i (max_len),
    .result_o  (parse_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= parse_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.payload_byte;
  assign m_axis_tuser  = {out_res_q.frame_error, out_res_q.payload_valid};
  assign m_axis_tlast  = out_res_q.frame_end;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q)
    else $error("stalled result was dropped");

endmodule
